// File: rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the dense-graph shortest-path engine.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int LANES     = 16;
    localparam int VERT_BITS = 4;
    localparam int DIST_BITS = 20;
    localparam int PRED_BITS = 5;

    localparam logic [DIST_BITS-1:0] DIST_MAX = 20'hFFFFF;
    localparam logic [PRED_BITS-1:0] NO_PRED  = 5'd31;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // broadcast command to every cell
    typedef struct packed {
        logic                  init;
        logic                  mark;
        logic                  relax;
        logic                  edge_ok;
        logic [DIST_BITS-1:0]  cand;
        logic [VERT_BITS-1:0]  from_idx;
    } cell_cmd_t;

    // per-vertex search state
    typedef struct packed {
        logic [DIST_BITS-1:0]  dist_val;
        logic                  reached;
        logic                  visited;
        logic [PRED_BITS-1:0]  pred;
    } cell_state_t;

endpackage

// File: rtl/shortest_path_dense_graph_top.sv
// ----------------------------------------------------------------------------
// shortest_path_dense_graph_top
// Dijkstra engine over a dense directed adjacency table.
// ----------------------------------------------------------------------------
// After reset the block sweeps the edge table to "no edge", one entry per
// cycle, and holds in_stall high meanwhile. A query with n vertices in use
// runs up to n search rounds: every round marks the nearest open vertex,
// then streams its table row one entry per cycle through the row of vertex
// cells, relaxing one cell per cycle while folding the next round's minimum.
// A check state follows, then the predecessor walk stacks the path from the
// target back to the source, and the path is emitted source first, one beat
// per cycle when out_stall is low. The single read port of the edge memory
// sets the row rate.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph_top #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [4:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [3:0]  from_vertex,
    input  logic [3:0]  to_vertex,
    input  logic        edge_present,
    input  logic [15:0] edge_weight,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  path_vertex,
    output logic [19:0] total_distance,
    output logic        unreachable,
    output logic        last
);

    localparam int ENTRIES = MAX_VERTICES * MAX_VERTICES;
    localparam int AW      = $clog2(ENTRIES);
    localparam int LIM     = (MAX_VERTICES < spd_pkg::LANES) ? MAX_VERTICES
                                                             : spd_pkg::LANES;
    localparam int SW      = ((WEIGHT_BITS > spd_pkg::DIST_BITS) ? WEIGHT_BITS
                                                                 : spd_pkg::DIST_BITS) + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ROUND, S_RELAX, S_CHECK, S_WALK, S_EMIT, S_FAIL
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        clr_reg;
    logic [4:0]           vc_reg;
    logic [4:0]           n_reg;
    logic [3:0]           src_reg;
    logic [3:0]           tgt_reg;
    logic [3:0]           u_reg;
    logic [19:0]          du_reg;
    logic [3:0]           c_reg;
    logic                 have_min_reg;
    logic [19:0]          min_dist_reg;
    logic [3:0]           min_idx_reg;
    logic [3:0]           v_reg;
    logic [4:0]           depth_reg;
    logic [3:0]           k_reg;
    logic [3:0]           stack_reg [spd_pkg::LANES];
    logic                 out_valid_reg;
    logic [3:0]           out_vertex_reg;
    logic [19:0]          out_dist_reg;
    logic                 out_unr_reg;
    logic                 out_last_reg;

    // edge memory: presence bit above the weight
    logic [WEIGHT_BITS:0] mem [ENTRIES];
    logic [WEIGHT_BITS:0] rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WEIGHT_BITS:0] mem_wdata;
    logic [AW-1:0]        rd_addr;
    logic [3:0]           rd_col;

    spd_pkg::cell_cmd_t   cmd;
    spd_pkg::cell_state_t cell_q [spd_pkg::LANES];
    spd_pkg::cell_state_t cell_n [spd_pkg::LANES];

    logic                 accept;
    logic                 wr_ok;
    logic [4:0]           n_eff;
    logic                 ends_ok;
    logic                 out_free;
    logic                 out_load;
    logic [SW-1:0]        sum;
    logic [19:0]          cand;
    spd_pkg::cell_state_t cur_n;
    logic                 take;
    logic                 row_end;
    spd_pkg::cell_state_t tgt_q;
    spd_pkg::cell_state_t vq;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_FAIL));

    // vertices in use, clamped to [1, LIM]
    always_comb
    begin
        if (vc_reg == 5'd0)
            n_eff = 5'd1;
        else if (32'(vc_reg) > LIM)
            n_eff = 5'(LIM);
        else
            n_eff = vc_reg;
    end

    assign ends_ok = ({1'b0, from_vertex} < n_eff) && ({1'b0, to_vertex} < n_eff);
    assign wr_ok   = (32'(from_vertex) < MAX_VERTICES) && (32'(to_vertex) < MAX_VERTICES);

    // memory ports
    assign mem_we    = (state_reg == S_CLEAR) || (accept && (mode == spd_pkg::MODE_WRITE) && wr_ok);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg
                     : AW'(32'(from_vertex) * MAX_VERTICES + 32'(to_vertex));
    assign mem_wdata = (state_reg == S_CLEAR) ? '0
                     : {edge_present, WEIGHT_BITS'(edge_weight)};
    assign rd_col    = (state_reg == S_ROUND) ? 4'd0 : (c_reg + 4'd1);
    assign rd_addr   = AW'(32'(u_reg) * MAX_VERTICES + 32'(rd_col));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data <= mem[rd_addr];
    end

    // saturating candidate distance
    assign sum  = SW'(du_reg) + SW'(rd_data[WEIGHT_BITS-1:0]);
    assign cand = (sum > SW'(spd_pkg::DIST_MAX)) ? spd_pkg::DIST_MAX : sum[19:0];

    always_comb
    begin
        cmd          = '0;
        cmd.init     = accept && (mode == spd_pkg::MODE_QUERY) && ends_ok;
        cmd.mark     = (state_reg == S_ROUND);
        cmd.relax    = (state_reg == S_RELAX);
        cmd.edge_ok  = rd_data[WEIGHT_BITS];
        cmd.cand     = cand;
        cmd.from_idx = u_reg;
    end

    // row of vertex cells
    for (genvar g = 0; g < spd_pkg::LANES; g++)
    begin : g_cell
        spd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .hit_src (from_vertex == 4'(g)),
            .hit_sel ((state_reg == S_ROUND) ? (u_reg == 4'(g)) : (c_reg == 4'(g))),
            .state_q (cell_q[g]),
            .state_n (cell_n[g])
        );
    end

    // running minimum for the next round, lowest index wins ties
    assign cur_n   = cell_n[c_reg];
    assign take    = cur_n.reached && !cur_n.visited &&
                     (!have_min_reg || (cur_n.dist_val < min_dist_reg));
    assign row_end = ({1'b0, c_reg} == (n_reg - 5'd1));
    assign tgt_q   = cell_q[tgt_reg];
    assign vq      = cell_q[v_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            vc_reg         <= 5'd16;
            out_valid_reg  <= 1'b0;
            out_vertex_reg <= '0;
            out_dist_reg   <= '0;
            out_unr_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
            n_reg          <= 5'd1;
            src_reg        <= '0;
            tgt_reg        <= '0;
            u_reg          <= '0;
            du_reg         <= '0;
            c_reg          <= '0;
            have_min_reg   <= 1'b0;
            min_dist_reg   <= '0;
            min_idx_reg    <= '0;
            v_reg          <= '0;
            depth_reg      <= '0;
            k_reg          <= '0;
            for (int i = 0; i < spd_pkg::LANES; i++)
                stack_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write_en)
                vc_reg <= cfg_write_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept && (mode == spd_pkg::MODE_QUERY))
                    begin
                        n_reg   <= n_eff;
                        src_reg <= from_vertex;
                        tgt_reg <= to_vertex;
                        u_reg   <= from_vertex;
                        state_reg <= ends_ok ? S_ROUND : S_FAIL;
                    end
                end
                S_ROUND:
                begin
                    du_reg       <= cell_q[u_reg].dist_val;
                    c_reg        <= '0;
                    have_min_reg <= 1'b0;
                    state_reg    <= S_RELAX;
                end
                S_RELAX:
                begin
                    if (take)
                    begin
                        have_min_reg <= 1'b1;
                        min_dist_reg <= cur_n.dist_val;
                        min_idx_reg  <= c_reg;
                    end
                    c_reg <= c_reg + 4'd1;
                    if (row_end)
                    begin
                        if (take || have_min_reg)
                        begin
                            u_reg     <= take ? c_reg : min_idx_reg;
                            state_reg <= S_ROUND;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                begin
                    v_reg     <= tgt_reg;
                    depth_reg <= '0;
                    state_reg <= tgt_q.reached ? S_WALK : S_FAIL;
                end
                S_WALK:
                begin
                    stack_reg[depth_reg[3:0]] <= v_reg;
                    if ((v_reg == src_reg) || vq.pred[4] || (depth_reg + 5'd1 == n_reg))
                    begin
                        k_reg     <= depth_reg[3:0];
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        v_reg     <= vq.pred[3:0];
                        depth_reg <= depth_reg + 5'd1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_vertex_reg <= stack_reg[k_reg];
                        out_dist_reg   <= tgt_q.dist_val;
                        out_unr_reg    <= 1'b0;
                        out_last_reg   <= (k_reg == 4'd0);
                        k_reg          <= k_reg - 4'd1;
                        if (k_reg == 4'd0)
                            state_reg <= S_IDLE;
                    end
                end
                S_FAIL:
                begin
                    if (out_free)
                    begin
                        out_vertex_reg <= tgt_reg;
                        out_dist_reg   <= spd_pkg::DIST_MAX;
                        out_unr_reg    <= 1'b1;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign path_vertex    = out_vertex_reg;
    assign total_distance = out_dist_reg;
    assign unreachable    = out_unr_reg;
    assign last           = out_last_reg;

endmodule

// File: rtl/spd_cell.sv
// ----------------------------------------------------------------------------
// spd_cell
// One vertex lane: best distance, reached/visited flags and predecessor.
// ----------------------------------------------------------------------------
module spd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spd_pkg::cell_cmd_t   cmd,
    input  logic                 hit_src,
    input  logic                 hit_sel,
    output spd_pkg::cell_state_t state_q,
    output spd_pkg::cell_state_t state_n
);

    spd_pkg::cell_state_t st_reg;
    spd_pkg::cell_state_t st_next;

    always_comb
    begin
        st_next = st_reg;
        if (cmd.init)
        begin
            st_next.dist_val = hit_src ? '0 : spd_pkg::DIST_MAX;
            st_next.reached  = hit_src;
            st_next.visited  = 1'b0;
            st_next.pred     = spd_pkg::NO_PRED;
        end
        else if (cmd.mark && hit_sel)
        begin
            st_next.visited = 1'b1;
        end
        else if (cmd.relax && hit_sel && cmd.edge_ok && !st_reg.visited &&
                 (!st_reg.reached || (cmd.cand < st_reg.dist_val)))
        begin
            st_next.dist_val = cmd.cand;
            st_next.reached  = 1'b1;
            st_next.pred     = {1'b0, cmd.from_idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.dist_val <= spd_pkg::DIST_MAX;
            st_reg.reached  <= 1'b0;
            st_reg.visited  <= 1'b0;
            st_reg.pred     <= spd_pkg::NO_PRED;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign state_q = st_reg;
    assign state_n = st_next;

endmodule
